// ----- rtl/bcmm_pkg.sv -----
// Package for the button chord and mode manager.
// Holds widths, event and register codes, and the types shared by the modules.
// Depends on nothing.
package bcmm_pkg;

  localparam int DEF_MAX_MASKS   = 8;
  localparam int DEF_BUTTON_BITS = 8;

  localparam int BTN_W      = 8;
  localparam int TIME_W     = 32;
  localparam int LP_W       = 31;
  localparam int MC_W       = 9;
  localparam int CNT_W      = 4;
  localparam int MW_W       = 16;
  localparam int NB_W       = 8;
  localparam int MASK_BYTE  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_W      = MW_W + 1;

  localparam logic [LP_W-1:0] HOLD_LIMIT_RESET = LP_W'(1000);
  localparam logic [MC_W-1:0] MODE_COUNT_RESET = MC_W'(1);
  localparam logic [MW_W-1:0] MODE_VALUE_RESET = MW_W'(1);

  typedef enum logic [1:0] {
    EV_MODE   = 2'd0,
    EV_PRESS  = 2'd1,
    EV_HSTART = 2'd2,
    EV_HEND   = 2'd3
  } bcmm_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_LIMIT    = 3'd0,
    REG_MODE_COUNT    = 3'd1,
    REG_NORMAL_COUNT  = 3'd2,
    REG_NORMAL_MASKS  = 3'd3,
    REG_MODE_CNT      = 3'd4,
    REG_MODE_MASKS    = 3'd5,
    REG_MODIFIER_CNT  = 3'd6,
    REG_MODIFIER_MASK = 3'd7
  } bcmm_reg_t;

  typedef struct packed {
    bcmm_kind_t       kind;
    logic [MW_W-1:0]  mode_word;
    logic             modifier_held;
    logic             long_hold;
    logic [NB_W-1:0]  normal_bits;
    logic             hold_first;
    logic             hold_was_long;
  } bcmm_res_t;

  typedef struct packed {
    logic capture;
    logic phase1;
    logic phase2;
    logic div_start;
    logic mode_fin;
    logic emit;
    logic emit_sel;
    logic emit_last;
  } bcmm_cmd_t;

  typedef struct packed {
    logic [1:0] count;
    logic       fire;
    logic       mode_fire;
    logic       need_div;
    logic       div_done;
    logic       out_free;
  } bcmm_stat_t;

endpackage

// ----- rtl/bcmm_if.sv -----
// Stream interfaces for the button chord and mode manager.
// Depends on bcmm_pkg for the field widths.
interface bcmm_in_if import bcmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BTN_W-1:0]  button_states;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output button_states, output now_ms, input ready);
  modport sink (input valid, input button_states, input now_ms, output ready);
endinterface

interface bcmm_out_if import bcmm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      event_kind;
  logic [MW_W-1:0] mode_word;
  logic            modifier_held;
  logic            long_hold;
  logic [NB_W-1:0] normal_bits;
  logic            hold_first;
  logic            hold_was_long;
  logic            last;

  modport source (output valid, output event_kind, output mode_word, output modifier_held,
                  output long_hold, output normal_bits, output hold_first,
                  output hold_was_long, output last, input ready);
  modport sink (input valid, input event_kind, input mode_word, input modifier_held,
                input long_hold, input normal_bits, input hold_first,
                input hold_was_long, input last, output ready);
endinterface

// ----- rtl/button_chord_mode_manager.sv -----
// Button chord and mode manager, top level. Depends on bcmm_pkg, bcmm_if,
// bcmm_ctrl, bcmm_datapath and bcmm_rem.
// The first result is registered after the capture, phase one and phase two steps; a
// mode change adds the mode finish step, and the bit-serial remainder unit when it runs.
// A new input is taken only after the results are handed on. Synchronous reset restores
// the control, configuration and block state and output valid, but not the payload.
module button_chord_mode_manager import bcmm_pkg::*; #(
  parameter int MAX_MASKS   = DEF_MAX_MASKS,
  parameter int BUTTON_BITS = DEF_BUTTON_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  bcmm_in_if.sink               in_ch,
  bcmm_out_if.source            out_ch,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  // The controller accepts a beat only from its idle state. Each beat is
  // captured, then evaluated in two phases: the first applies the change of
  // buttons to the hold timer, the second checks release or timer expiry with
  // the updated timer and fires a press or a mode change. Results wait in two
  // slots and move one at a time into the output register, so a new beat can be
  // taken while the last result of the previous one still waits downstream.
  bcmm_cmd_t  cmd;
  bcmm_stat_t stat;
  bcmm_res_t  out_res;
  logic       out_valid;
  logic       out_last;

  bcmm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  bcmm_datapath #(.MAX_MASKS(MAX_MASKS), .BUTTON_BITS(BUTTON_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .button_states(in_ch.button_states),
    .now_ms       (in_ch.now_ms),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ch.ready),
    .out_res      (out_res),
    .out_last     (out_last)
  );

  // The output beat comes straight from the datapath's output register.
  assign out_ch.valid         = out_valid;
  assign out_ch.event_kind    = out_res.kind;
  assign out_ch.mode_word     = out_res.mode_word;
  assign out_ch.modifier_held = out_res.modifier_held;
  assign out_ch.long_hold     = out_res.long_hold;
  assign out_ch.normal_bits   = out_res.normal_bits;
  assign out_ch.hold_first    = out_res.hold_first;
  assign out_ch.hold_was_long = out_res.hold_was_long;
  assign out_ch.last          = out_last;
endmodule

// ----- rtl/bcmm_rem.sv -----
// Restoring remainder unit, one quotient bit per cycle.
// Depends on bcmm_pkg for the default widths NUM_W and MC_W; widths come from parameters.
module bcmm_rem import bcmm_pkg::*; #(
  parameter int N_W = NUM_W,
  parameter int D_W = MC_W
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           done,
  output logic [D_W-1:0] rem
);
  localparam int C_W = $clog2(N_W + 1);

  logic           busy;
  logic [C_W-1:0] cnt;
  logic [N_W-1:0] num_r;
  logic [D_W-1:0] rem_r;
  logic [D_W:0]   trial;
  logic [D_W-1:0] rem_next;

  // The partial remainder stays below the divisor, so the trial fits one extra bit.
  always_comb begin
    trial = {rem_r, num_r[N_W-1]};
    if (trial >= {1'b0, den}) begin
      rem_next = D_W'(trial - {1'b0, den});
    end else begin
      rem_next = D_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == C_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= C_W'(N_W);
      num_r <= num;
      rem_r <= '0;
    end else if (busy) begin
      cnt   <= cnt - C_W'(1);
      num_r <= num_r << 1;
      rem_r <= rem_next;
    end
  end

  assign rem = rem_r;
endmodule

// ----- rtl/bcmm_datapath.sv -----
// Datapath: configuration registers, button and timer state, result slots,
// the mode remainder unit and the output register. Depends on bcmm_pkg and bcmm_rem.
module bcmm_datapath import bcmm_pkg::*; #(
  parameter int MAX_MASKS   = DEF_MAX_MASKS,
  parameter int BUTTON_BITS = DEF_BUTTON_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BTN_W-1:0]      button_states,
  input  logic [TIME_W-1:0]     now_ms,
  input  bcmm_cmd_t             cmd,
  output bcmm_stat_t            stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bcmm_res_t             out_res,
  output logic                  out_last
);
  // Configuration.
  logic [LP_W-1:0]       hold_limit_ms;
  logic [MC_W-1:0]       mode_count;
  logic [CNT_W-1:0]      normal_cnt, mode_cnt, modifier_cnt;
  logic [CFG_DATA_W-1:0] normal_masks, mode_masks, modifier_masks;

  // Block state.
  logic [BUTTON_BITS-1:0] cur, acc;
  logic [MW_W-1:0]        mode_value;
  logic                   running;
  logic [TIME_W-1:0]      start_ms;
  logic                   done_flag;
  logic [1:0]             count;

  // Per-item payload.
  logic [BUTTON_BITS-1:0] nb_q;
  logic [TIME_W-1:0]      now_q;
  logic                   rel_q;
  logic                   mode_slot;
  bcmm_res_t              slots [2];

  function automatic logic [MAX_MASKS-1:0] grp(input logic [BUTTON_BITS-1:0] s,
                                               input logic [CNT_W-1:0] cnt,
                                               input logic [CFG_DATA_W-1:0] masks);
    logic [MAX_MASKS-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_MASKS; i++) begin
      if (i < int'(cnt) && (s & masks[MASK_BYTE*i +: BUTTON_BITS]) != '0) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Phase one terms.
  logic [BUTTON_BITS-1:0] added, removed, acc_n;
  logic                   start_c, stop_c;

  assign added   = ~cur & nb_q;
  assign removed = cur & ~nb_q;
  assign acc_n   = acc | nb_q;
  assign start_c = (grp(added, normal_cnt, normal_masks) != '0) ||
                   (grp(added, modifier_cnt, modifier_masks) != '0);
  assign stop_c  = grp(acc_n, mode_cnt, mode_masks) != '0;

  // Phase two and mode terms, all from the state left by phase one.
  logic                 expired;
  logic [MAX_MASKS-1:0] g_mode, g_norm, g_modf;
  logic [CNT_W-1:0]     type_w;
  logic [MW_W-1:0]      type_mask, old_type, old_num;
  logic                 need_div;
  logic [CNT_W-1:0]     low_idx;
  logic [MC_W-1:0]      rem, new_num;
  logic [MW_W-1:0]      new_word;
  logic                 div_done;

  assign expired   = running && ((now_q - start_ms) > {1'b0, hold_limit_ms});
  assign g_mode    = grp(acc, mode_cnt, mode_masks);
  assign g_norm    = grp(acc, normal_cnt, normal_masks);
  assign g_modf    = grp(acc, modifier_cnt, modifier_masks);
  assign type_w    = (mode_cnt > CNT_W'(MAX_MASKS)) ? CNT_W'(MAX_MASKS) : mode_cnt;
  assign type_mask = (MW_W'(1) << type_w) - MW_W'(1);
  assign old_type  = mode_value & type_mask;
  assign old_num   = mode_value >> type_w;
  assign need_div  = (g_norm == '0) && (MW_W'(g_mode) == old_type) && (mode_count != '0);

  always_comb begin
    low_idx = '0;
    for (int i = MAX_MASKS - 1; i >= 0; i--) begin
      if (g_norm[i]) begin
        low_idx = CNT_W'(i);
      end
    end
  end

  always_comb begin
    if (g_norm != '0) begin
      new_num = MC_W'(low_idx);
    end else if (need_div) begin
      new_num = rem;
    end else begin
      new_num = '0;
    end
  end

  assign new_word = (MW_W'(new_num) << type_w) | MW_W'(g_mode);

  bcmm_rem #(.N_W(NUM_W), .D_W(MC_W)) u_rem (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (NUM_W'(old_num) + NUM_W'(1)),
    .den  (mode_count),
    .done (div_done),
    .rem  (rem)
  );

  always_comb begin
    stat.count     = count;
    stat.fire      = !done_flag && (rel_q || expired);
    stat.mode_fire = g_mode != '0;
    stat.need_div  = need_div;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || out_ready;
  end

  // Results of each phase, built whole before they land in a slot.
  bcmm_res_t p1_res, fire_res, hend_res;

  always_comb begin
    p1_res            = '0;
    p1_res.kind       = start_c ? EV_HSTART : EV_HEND;
    p1_res.hold_first = start_c && !running;

    fire_res      = '0;
    fire_res.kind = stat.mode_fire ? EV_MODE : EV_PRESS;
    if (!stat.mode_fire) begin
      fire_res.mode_word     = mode_value;
      fire_res.modifier_held = g_modf != '0;
      fire_res.long_hold     = expired;
      fire_res.normal_bits   = NB_W'(g_norm);
    end

    hend_res               = '0;
    hend_res.kind          = EV_HEND;
    hend_res.hold_was_long = expired;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit_ms  <= HOLD_LIMIT_RESET;
      mode_count     <= MODE_COUNT_RESET;
      normal_cnt     <= '0;
      mode_cnt       <= '0;
      modifier_cnt   <= '0;
      normal_masks   <= '0;
      mode_masks     <= '0;
      modifier_masks <= '0;
      cur            <= '0;
      acc            <= '0;
      mode_value     <= MODE_VALUE_RESET;
      running        <= 1'b0;
      start_ms       <= '0;
      done_flag      <= 1'b0;
      count          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (bcmm_reg_t'(cfg_index))
          REG_HOLD_LIMIT:    hold_limit_ms  <= cfg_data[LP_W-1:0];
          REG_MODE_COUNT:    mode_count     <= cfg_data[MC_W-1:0];
          REG_NORMAL_COUNT:  normal_cnt     <= cfg_data[CNT_W-1:0];
          REG_NORMAL_MASKS:  normal_masks   <= cfg_data;
          REG_MODE_CNT:      mode_cnt       <= cfg_data[CNT_W-1:0];
          REG_MODE_MASKS:    mode_masks     <= cfg_data;
          REG_MODIFIER_CNT:  modifier_cnt   <= cfg_data[CNT_W-1:0];
          REG_MODIFIER_MASK: modifier_masks <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.phase1) begin
        cur <= nb_q;
        acc <= acc_n;
        if (start_c) begin
          running  <= 1'b1;
          start_ms <= now_q;
          count    <= 2'd1;
        end else if (stop_c) begin
          running <= 1'b0;
          count   <= running ? 2'd1 : 2'd0;
        end else begin
          count <= 2'd0;
        end
      end

      if (cmd.phase2) begin
        if (stat.fire) begin
          running   <= 1'b0;
          done_flag <= 1'b1;
          count     <= count + 2'd1 + {1'b0, running};
        end else if (done_flag && cur == '0) begin
          done_flag <= 1'b0;
          acc       <= '0;
        end
      end

      if (cmd.mode_fin) begin
        mode_value <= new_word;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers; the result slots are written in the order the events occur.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nb_q  <= button_states[BUTTON_BITS-1:0];
      now_q <= now_ms;
    end

    if (cmd.phase1) begin
      rel_q    <= (nb_q == '0) && (removed != '0);
      slots[0] <= p1_res;
    end

    if (cmd.phase2 && stat.fire) begin
      mode_slot       <= count[0];
      slots[count[0]] <= fire_res;
      if (running) begin
        slots[~count[0]] <= hend_res;
      end
    end

    if (cmd.mode_fin) begin
      slots[mode_slot].mode_word <= new_word;
    end

    if (cmd.emit) begin
      out_res  <= slots[cmd.emit_sel];
      out_last <= cmd.emit_last;
    end
  end
endmodule

// ----- rtl/bcmm_ctrl.sv -----
// Controller state machine: sequences capture, the two evaluation phases,
// the mode remainder and the hand-off of results. Depends on bcmm_pkg.
module bcmm_ctrl import bcmm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  bcmm_stat_t stat,
  output bcmm_cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_PH1, S_PH2, S_DIV, S_MFIN, S_EMIT0, S_EMIT1
  } state_t;

  state_t state;

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_PH1: cmd.phase1 = 1'b1;
      S_PH2: begin
        cmd.phase2    = 1'b1;
        cmd.div_start = stat.fire && stat.mode_fire && stat.need_div;
      end
      S_DIV: ;
      S_MFIN: cmd.mode_fin = 1'b1;
      S_EMIT0: begin
        cmd.emit      = stat.out_free && stat.count != 2'd0;
        cmd.emit_sel  = 1'b0;
        cmd.emit_last = stat.count == 2'd1;
      end
      S_EMIT1: begin
        cmd.emit      = stat.out_free;
        cmd.emit_sel  = 1'b1;
        cmd.emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_PH1;
        end
        S_PH1: state <= S_PH2;
        S_PH2: begin
          if (stat.fire && stat.mode_fire) begin
            state <= stat.need_div ? S_DIV : S_MFIN;
          end else begin
            state <= S_EMIT0;
          end
        end
        S_DIV: begin
          if (stat.div_done) state <= S_MFIN;
        end
        S_MFIN: state <= S_EMIT0;
        S_EMIT0: begin
          if (stat.count == 2'd0) begin
            state <= S_IDLE;
          end else if (stat.out_free) begin
            state <= (stat.count == 2'd1) ? S_IDLE : S_EMIT1;
          end
        end
        S_EMIT1: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- bench/tb_button_chord_mode_manager.sv -----
`timescale 1ns / 1ps
// Self-checking bench for button_chord_mode_manager: it drives snapshots and register
// writes and checks every event beat against an in-bench model of the chord logic.
// Depends on bcmm_pkg, bcmm_if and the block itself.
module tb_button_chord_mode_manager;
  import bcmm_pkg::*;

  // Group selectors for the three mask sets that the model keeps side by side.
  localparam int GRP_NORMAL   = 0;
  localparam int GRP_MODE     = 1;
  localparam int GRP_MODIFIER = 2;

  // Cycles to let pass after the last expected beat before touching registers.
  // A cycled mode number runs through the bit-serial remainder unit, which is the
  // slowest path of the block.
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 3000;

  // One event beat as it appears on the result channel.
  typedef struct packed {
    bcmm_res_t res;
    logic      last;
  } chord_event_t;

  // One full register setting.
  typedef struct packed {
    logic [LP_W-1:0]       hold_limit;
    logic [MC_W-1:0]       cycle_len;
    logic [CNT_W-1:0]      normal_cnt;
    logic [CFG_DATA_W-1:0] normal_set;
    logic [CNT_W-1:0]      mode_cnt;
    logic [CFG_DATA_W-1:0] mode_set;
    logic [CNT_W-1:0]      modifier_cnt;
    logic [CFG_DATA_W-1:0] modifier_set;
  } cfg_set_t;

  // The chord tracker mirrors the block: it holds a copy of the registers and of the
  // button, hold-timer and mode state, works out the events of every accepted
  // snapshot, and checks result beats against them in order.
  class chord_tracker;
    logic [LP_W-1:0]       hold_limit;
    logic [MC_W-1:0]       cycle_len;
    logic [CNT_W-1:0]      grp_cnt [3];
    logic [CFG_DATA_W-1:0] grp_masks [3];

    logic [BTN_W-1:0]  cur_btn;
    logic [BTN_W-1:0]  acc_btn;
    logic [MW_W-1:0]   mode_val;
    bit                hold_on;
    logic [TIME_W-1:0] hold_t0;
    bit                fired;

    chord_event_t awaited_events [$];
    chord_event_t step_events [$];
    int           failures;

    function void reset();
      hold_limit = HOLD_LIMIT_RESET;
      cycle_len  = MODE_COUNT_RESET;
      for (int g = 0; g < 3; g++) begin
        grp_cnt[g]   = '0;
        grp_masks[g] = '0;
      end
      cur_btn  = '0;
      acc_btn  = '0;
      mode_val = MODE_VALUE_RESET;
      hold_on  = 0;
      hold_t0  = '0;
      fired    = 0;
      failures = 0;
      awaited_events.delete();
    endfunction

    function void write_reg(bcmm_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_HOLD_LIMIT:    hold_limit = data[LP_W-1:0];
        REG_MODE_COUNT:    cycle_len = data[MC_W-1:0];
        REG_NORMAL_COUNT:  grp_cnt[GRP_NORMAL] = data[CNT_W-1:0];
        REG_NORMAL_MASKS:  grp_masks[GRP_NORMAL] = data;
        REG_MODE_CNT:      grp_cnt[GRP_MODE] = data[CNT_W-1:0];
        REG_MODE_MASKS:    grp_masks[GRP_MODE] = data;
        REG_MODIFIER_CNT:  grp_cnt[GRP_MODIFIER] = data[CNT_W-1:0];
        REG_MODIFIER_MASK: grp_masks[GRP_MODIFIER] = data;
        default: ;
      endcase
    endfunction

    function int clamp_cnt(logic [CNT_W-1:0] c);
      return (c > DEF_MAX_MASKS) ? DEF_MAX_MASKS : int'(c);
    endfunction

    // Bit i is set when mask i of the group hits any button of s.
    function logic [7:0] group_hits(logic [BTN_W-1:0] s, int g);
      logic [7:0] r;
      int         n;
      r = '0;
      n = clamp_cnt(grp_cnt[g]);
      for (int i = 0; i < n; i++)
        if ((s & grp_masks[g][MASK_BYTE*i +: MASK_BYTE]) != 0) r[i] = 1'b1;
      return r;
    endfunction

    function bit hold_expired(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] held_for;
      held_for = now - hold_t0;
      return hold_on && (held_for > {1'b0, hold_limit});
    endfunction

    function void add_event(bcmm_kind_t kind, logic [MW_W-1:0] word, logic mod_held,
                            logic lng, logic [NB_W-1:0] nbits, logic first,
                            logic was_long);
      chord_event_t e;
      if (step_events.size() >= 2) return;
      e.res.kind          = kind;
      e.res.mode_word     = word;
      e.res.modifier_held = mod_held;
      e.res.long_hold     = lng;
      e.res.normal_bits   = nbits;
      e.res.hold_first    = first;
      e.res.hold_was_long = was_long;
      e.last              = 1'b0;
      step_events.push_back(e);
    endfunction

    function void end_hold(bit finished, logic [TIME_W-1:0] now);
      if (hold_on)
        add_event(EV_HEND, '0, 0, 0, '0, 0, finished && hold_expired(now));
      hold_on = 0;
    endfunction

    function void fire_mode_change();
      int unsigned n, old_type, old_num, new_type, num;
      logic [7:0]  nbits;
      n        = clamp_cnt(grp_cnt[GRP_MODE]);
      old_type = mode_val & ((32'd1 << n) - 32'd1);
      old_num  = mode_val >> n;
      new_type = group_hits(acc_btn, GRP_MODE);
      nbits    = group_hits(acc_btn, GRP_NORMAL);
      if (new_type != old_type) num = 0;
      else if (cycle_len != 0) num = (old_num + 1) % cycle_len;
      else num = 0;
      // A held normal button picks its own mode number: the lowest one wins.
      for (int i = 7; i >= 0; i--)
        if (nbits[i]) num = i;
      mode_val = MW_W'((num << n) | new_type);
      add_event(EV_MODE, mode_val, 0, 0, '0, 0, 0);
    endfunction

    function void note_snapshot(logic [BTN_W-1:0] btn, logic [TIME_W-1:0] now);
      logic [BTN_W-1:0] added, removed;
      added   = ~cur_btn & btn;
      removed = cur_btn & ~btn;
      step_events.delete();
      cur_btn = btn;
      acc_btn = acc_btn | btn;

      if (group_hits(added, GRP_NORMAL) != 0 || group_hits(added, GRP_MODIFIER) != 0) begin
        add_event(EV_HSTART, '0, 0, 0, '0, !hold_on, 0);
        hold_on = 1;
        hold_t0 = now;
      end else if (group_hits(acc_btn, GRP_MODE) != 0) begin
        end_hold(0, now);
      end

      if (!fired) begin
        if ((cur_btn == 0 && removed != 0) || hold_expired(now)) begin
          if (group_hits(acc_btn, GRP_MODE) != 0)
            fire_mode_change();
          else
            add_event(EV_PRESS, mode_val, group_hits(acc_btn, GRP_MODIFIER) != 0,
                      hold_expired(now), group_hits(acc_btn, GRP_NORMAL), 0, 0);
          end_hold(1, now);
          fired = 1;
        end
      end else if (cur_btn == 0) begin
        fired   = 0;
        acc_btn = '0;
      end

      if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
      foreach (step_events[i]) awaited_events.push_back(step_events[i]);
    endfunction

    function string show(chord_event_t e);
      return $sformatf("kind=%0d word=%h mod=%b long=%b normal=%b first=%b was_long=%b last=%b",
                       e.res.kind, e.res.mode_word, e.res.modifier_held, e.res.long_hold,
                       e.res.normal_bits, e.res.hold_first, e.res.hold_was_long, e.last);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function void check_event(chord_event_t got);
      chord_event_t want;
      string        bad;
      if (awaited_events.size() == 0) begin
        note_failure({"event beat with nothing expected: ", show(got)});
        return;
      end
      want = awaited_events.pop_front();
      bad  = "";
      if (got.res.kind !== want.res.kind) bad = {bad, " kind"};
      if (got.res.mode_word !== want.res.mode_word) bad = {bad, " mode_word"};
      if (got.res.modifier_held !== want.res.modifier_held) bad = {bad, " modifier_held"};
      if (got.res.long_hold !== want.res.long_hold) bad = {bad, " long_hold"};
      if (got.res.normal_bits !== want.res.normal_bits) bad = {bad, " normal_bits"};
      if (got.res.hold_first !== want.res.hold_first) bad = {bad, " hold_first"};
      if (got.res.hold_was_long !== want.res.hold_was_long) bad = {bad, " hold_was_long"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (bad != "")
        note_failure($sformatf("field(s)%s differ: expected %s, got %s",
                               bad, show(want), show(got)));
    endfunction

    function void report_leftovers();
      while (awaited_events.size() != 0)
        note_failure({"expected event never arrived: ", show(awaited_events.pop_front())});
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bcmm_in_if  in_ch ();
  bcmm_out_if out_ch ();

  button_chord_mode_manager uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chord_tracker sb;

  // Snapshot time advanced by the stimulus, and the time of the most recent press in a chord.
  logic [TIME_W-1:0] wall;
  logic [TIME_W-1:0] press_at;
  // While set, the matching side runs with no idle cycles at all.
  bit quiet_in;
  bit quiet_out;
  int items_sent;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: for every beat a fresh random stall is drawn with ready low (none while
  // quiet_out is set), then ready stays high until a beat is taken. A stall of zero keeps ready high
  // across back-to-back beats, so the block also sees long stretches with no back
  // pressure.
  initial begin
    int           stall;
    chord_event_t got;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.res.kind          = bcmm_kind_t'(out_ch.event_kind);
      got.res.mode_word     = out_ch.mode_word;
      got.res.modifier_held = out_ch.modifier_held;
      got.res.long_hold     = out_ch.long_hold;
      got.res.normal_bits   = out_ch.normal_bits;
      got.res.hold_first    = out_ch.hold_first;
      got.res.hold_was_long = out_ch.hold_was_long;
      got.last              = out_ch.last;
      sb.check_event(got);
    end
  end

  // Offers one snapshot after a random idle gap and returns at the edge where the
  // beat is taken. Valid is left high so the next snapshot can follow without a gap.
  task automatic send_snapshot(input logic [BTN_W-1:0] btn, input logic [TIME_W-1:0] now);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.button_states <= btn;
    in_ch.now_ms        <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_snapshot(btn, now);
    items_sent++;
  endtask

  // Stops the input stream and waits until every expected beat has arrived, plus the
  // settle time for a snapshot that is still being worked on but yields no event.
  task automatic drain();
    int spins;
    spins = 0;
    in_ch.valid <= 1'b0;
    while (sb.awaited_events.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: set up at this edge, taken by the block at the next one.
  // The write enable stays high between back-to-back writes.
  task automatic write_one(input bcmm_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic program_regs(input cfg_set_t c);
    write_one(REG_HOLD_LIMIT, CFG_DATA_W'(c.hold_limit));
    write_one(REG_MODE_COUNT, CFG_DATA_W'(c.cycle_len));
    write_one(REG_NORMAL_COUNT, CFG_DATA_W'(c.normal_cnt));
    write_one(REG_NORMAL_MASKS, c.normal_set);
    write_one(REG_MODE_CNT, CFG_DATA_W'(c.mode_cnt));
    write_one(REG_MODE_MASKS, c.mode_set);
    write_one(REG_MODIFIER_CNT, CFG_DATA_W'(c.modifier_cnt));
    write_one(REG_MODIFIER_MASK, c.modifier_set);
    cfg_write <= 1'b0;
  endtask

  // Masks that each name one button or none, so that the groups stay distinct enough
  // for presses, mode changes and modifiers to all show up.
  function automatic logic [CFG_DATA_W-1:0] sparse_masks();
    logic [CFG_DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DEF_MAX_MASKS; i++)
      if ($urandom_range(0, 4) != 0) m[MASK_BYTE*i +: MASK_BYTE] = 8'(1) << $urandom_range(0, 7);
    return m;
  endfunction

  // Settings for the random phases: both ends of the hold limit, a zero and a maximal
  // cycle length, mask counts above the supported eight, and dense as well as sparse
  // mask sets.
  function automatic cfg_set_t phase_setting(int k);
    cfg_set_t c;
    c.hold_limit   = LP_W'($urandom_range(0, 5000));
    c.cycle_len    = MC_W'($urandom_range(0, 511));
    c.normal_cnt   = CNT_W'($urandom_range(0, 15));
    c.mode_cnt     = CNT_W'($urandom_range(0, 15));
    c.modifier_cnt = CNT_W'($urandom_range(0, 15));
    c.normal_set   = sparse_masks();
    c.mode_set     = sparse_masks();
    c.modifier_set = sparse_masks();
    case (k)
      0: begin
        c.hold_limit   = '0;
        c.cycle_len    = MC_W'(256);
        c.normal_cnt   = CNT_W'(8);
        c.mode_cnt     = CNT_W'(8);
        c.modifier_cnt = CNT_W'(8);
      end
      1: begin
        c.hold_limit   = '1;
        c.cycle_len    = '0;
        c.normal_cnt   = '1;
        c.mode_cnt     = CNT_W'(9);
        c.modifier_cnt = CNT_W'(12);
      end
      2: begin
        c.hold_limit   = LP_W'(1000);
        c.cycle_len    = MC_W'(1);
        c.normal_cnt   = '0;
        c.mode_cnt     = '0;
        c.modifier_cnt = '0;
        c.normal_set   = '1;
        c.mode_set     = '1;
        c.modifier_set = '1;
      end
      3: begin
        c.hold_limit   = LP_W'($urandom_range(1, 300));
        c.cycle_len    = '1;
        c.mode_set     = {$urandom, $urandom};
      end
      4: begin
        // Every button is a normal button of its own; the top three also pick the
        // mode type, and button 4 is a modifier.
        c.hold_limit   = LP_W'(50);
        c.cycle_len    = MC_W'($urandom_range(1, 256));
        c.normal_cnt   = CNT_W'(8);
        c.normal_set   = 64'h8040_2010_0804_0201;
        c.mode_cnt     = CNT_W'(3);
        c.mode_set     = 64'h0000_0000_0020_4080;
        c.modifier_cnt = CNT_W'(1);
        c.modifier_set = 64'h0000_0000_0000_0010;
      end
      default: ;
    endcase
    return c;
  endfunction

  // A well-formed chord: one to three presses, sometimes a hold that reaches the long
  // press limit (right at it, one or two past it, sometimes well beyond), sometimes a partial
  // release, then release of all buttons.
  task automatic run_chord();
    logic [BTN_W-1:0] held;
    int               presses;
    held    = '0;
    presses = $urandom_range(1, 3);
    repeat (presses) begin
      held = held | (8'(1) << $urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) held = held | (8'(1) << $urandom_range(0, 7));
      wall     = wall + 32'($urandom_range(0, 40));
      press_at = wall;
      send_snapshot(held, wall);
    end
    if ($urandom_range(0, 2) == 0) begin
      wall = press_at + {1'b0, sb.hold_limit} + 32'($urandom_range(0, 2));
      send_snapshot(held, wall);
      if ($urandom_range(0, 1) == 0) begin
        wall = wall + 32'($urandom_range(0, 500));
        send_snapshot(held, wall);
      end
    end
    if ($urandom_range(0, 3) == 0 && $countones(held) > 1) begin
      held = held & (held - 8'd1);
      wall = wall + 32'($urandom_range(0, 60));
      send_snapshot(held, wall);
    end
    if ($urandom_range(0, 5) == 0) wall = wall + $urandom;
    else wall = wall + 32'($urandom_range(0, 60));
    send_snapshot('0, wall);
  endtask

  // Stimulus: a couple of snapshots at the reset settings, a directed chord walk
  // through every event kind, then six random phases of about a hundred snapshots.
  initial begin
    logic [BTN_W-1:0]  walk_btn [26];
    logic [TIME_W-1:0] walk_ms [26];
    cfg_set_t          walk_cfg;
    int                target;

    sb = new;
    sb.reset();
    wall       = '0;
    press_at   = '0;
    quiet_in   = 0;
    quiet_out  = 0;
    items_sent = 0;

    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_HOLD_LIMIT;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.button_states = '0;
    in_ch.now_ms        = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // With no masks in use nothing starts the timer; releasing still fires a bare
    // press that carries the reset mode word.
    send_snapshot(8'h01, 32'd0);
    send_snapshot(8'h00, 32'd5);
    drain();

    // Directed walk. Buttons 0 to 3 are normal, 4 and 5 choose the mode type,
    // 6 and 7 are modifiers; the long-press limit is 100 ms and modes cycle by three.
    walk_cfg.hold_limit   = LP_W'(100);
    walk_cfg.cycle_len    = MC_W'(3);
    walk_cfg.normal_cnt   = CNT_W'(4);
    walk_cfg.normal_set   = 64'h0000_0000_0804_0201;
    walk_cfg.mode_cnt     = CNT_W'(2);
    walk_cfg.mode_set     = 64'h0000_0000_0000_2010;
    walk_cfg.modifier_cnt = CNT_W'(2);
    walk_cfg.modifier_set = 64'h0000_0000_0000_8040;
    program_regs(walk_cfg);

    // First hold start, a restart, a short press and its hold end; a modifier chord
    // held exactly to the limit and then one past it (long press); mode button taps
    // cycling the number through its wrap; a type change with a normal button picking
    // the number; a mode button cutting a running hold; a chord whose hold spans the
    // 32-bit time wrap; all buttons at the extreme times.
    walk_btn = '{8'h01, 8'h03, 8'h00, 8'h41, 8'h41, 8'h41, 8'h00, 8'h10, 8'h00,
                 8'h10, 8'h00, 8'h10, 8'h00, 8'h20, 8'h22, 8'h00, 8'h01, 8'h11,
                 8'h11, 8'h00, 8'hC3, 8'hC3, 8'hC1, 8'h00, 8'hFF, 8'h00};
    walk_ms  = '{32'd0, 32'd10, 32'd20, 32'd30, 32'd130, 32'd131, 32'd140, 32'd200,
                 32'd210, 32'd220, 32'd230, 32'd240, 32'd250, 32'd260, 32'd270,
                 32'd280, 32'd290, 32'd300, 32'd500, 32'd510, 32'hFFFF_FFF0,
                 32'h0000_0050, 32'h0000_0055, 32'h0000_0060, 32'hFFFF_FFFF, 32'd0};
    foreach (walk_btn[i]) send_snapshot(walk_btn[i], walk_ms[i]);
    drain();

    // Random phases: three chords for every noise snapshot. Both sides switch now and
    // then between random idling and running flat out.
    for (int p = 0; p < 6; p++) begin
      program_regs(phase_setting(p));
      target = items_sent + 105;
      while (items_sent < target) begin
        if ($urandom_range(0, 7) == 0) quiet_in = !quiet_in;
        if ($urandom_range(0, 7) == 0) quiet_out = !quiet_out;
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 3) == 0) wall = wall + $urandom;
          else wall = wall + 32'($urandom_range(0, 200));
          send_snapshot(8'($urandom_range(0, 255)), wall);
        end else begin
          run_chord();
        end
      end
      drain();
    end

    sb.report_leftovers();
    if (sb.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
